### src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to 16-bit character decoder.
// Used by the decode step, the top level and the port checker.
`default_nettype none

package u8u16_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [15:0] character;
		logic        last_character;
		logic        truncated;
	} out_word_t;

	typedef struct packed {
		logic [15:0] partial_code;
		logic [1:0]  bytes_pending;
	} dec_state_t;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'he0;
	localparam logic [7:0] LEAD2_CODE  = 8'hc0;

endpackage

`default_nettype wire

### src/u8u16_step.sv
// Combinational decode of one byte against the current sequence state.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_step (
	input  u8u16_pkg::in_word_t   word,
	input  u8u16_pkg::dec_state_t state,
	output u8u16_pkg::dec_state_t state_next,
	output logic                  emit,
	output u8u16_pkg::out_word_t  result
);
	import u8u16_pkg::*;

	logic [5:0]  payload;
	logic [15:0] code;
	logic [1:0]  pend;
	logic        done;

	assign payload = word.data_byte[5:0];

	always_comb begin
		code = state.partial_code;
		pend = state.bytes_pending;
		done = 1'b0;
		unique case (state.bytes_pending)
			PEND_ONE: begin
				code = state.partial_code | {10'd0, payload};
				pend = PEND_NONE;
				done = 1'b1;
			end
			PEND_TWO: begin
				code = state.partial_code | {4'd0, payload, 6'd0};
				pend = PEND_ONE;
			end
			default: begin
				// idle; a count of three cannot occur and is treated the same
				if (word.data_byte < ASCII_LIMIT) begin
					code = {8'd0, word.data_byte};
					pend = PEND_NONE;
					done = 1'b1;
				end else if ((word.data_byte & LEAD2_MASK) == LEAD2_CODE) begin
					code = {5'd0, word.data_byte[4:0], 6'd0};
					pend = PEND_ONE;
				end else begin
					// lead bit 4 drops out of the 16-bit code
					code = {word.data_byte[3:0], 12'd0};
					pend = PEND_TWO;
				end
			end
		endcase
	end

	always_comb begin
		emit                  = done || word.end_of_string;
		result.character      = code;
		result.last_character = word.end_of_string;
		result.truncated      = !done;
		if (emit) begin
			state_next = '{partial_code: 16'd0, bytes_pending: PEND_NONE};
		end else begin
			state_next = '{partial_code: code, bytes_pending: pend};
		end
	end

endmodule

`default_nettype wire

### src/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to 16-bit character decoder.
// Depends on u8u16_pkg and u8u16_step.
//
// Usage:
//   byte channel: one UTF-8 byte per word, with end_of_string on the final byte.
//   char channel: one 16-bit character per word; last_character marks the end
//   of a string, truncated marks a string that ended inside a sequence.
//   A byte is taken when byte_valid is high and byte_stall low; a character
//   is delivered when char_valid is high and char_stall low.
// Path: the byte that completes a character passes the input register, then
//   the result register, before the character appears on char_word.
// Throughput: one byte per cycle unless a held character stalls the input;
//   the decode is a single mask-and-shift between the two registers.
// Lead and middle bytes of a sequence produce no character unless they carry
//   end_of_string, which flushes the partial character.
// Reset: clears both registers' valid flags and the sequence state, so the
//   first byte after reset starts a new string.
// Stall: a held character keeps the byte register waiting; byte_stall rises
//   only when the input register is full behind a stalled result register.
`default_nettype none

module utf8_to_utf16_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  u8u16_pkg::in_word_t  byte_word,
	output logic                 char_valid,
	input  logic                 char_stall,
	output u8u16_pkg::out_word_t char_word
);
	import u8u16_pkg::*;

	logic       valid_s1;
	in_word_t   word_s1;
	dec_state_t state_q;
	dec_state_t state_next;
	logic       emit;
	out_word_t  result;
	logic       out_valid_q;
	out_word_t  out_word_q;
	logic       advance;
	logic       take_in;

	assign advance    = valid_s1 && (!out_valid_q || !char_stall);
	assign byte_stall = valid_s1 && !advance;
	assign take_in    = byte_valid && !byte_stall;
	assign char_valid = out_valid_q;
	assign char_word  = out_word_q;

	u8u16_step u_step (
		.word       (word_s1),
		.state      (state_q),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{partial_code: 16'd0, bytes_pending: PEND_NONE};
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (!char_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= byte_word;
		end
		if (advance && emit) begin
			out_word_q <= result;
		end
	end

endmodule

`default_nettype wire

### src/u8u16_checker.sv
// Port-level checks for the UTF-8 to 16-bit character decoder, bound to the
// top level. Depends on u8u16_pkg.
`default_nettype none

module u8u16_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input u8u16_pkg::in_word_t  byte_word,
	input logic                 char_valid,
	input logic                 char_stall,
	input u8u16_pkg::out_word_t char_word
);
	import u8u16_pkg::*;

	// a held character word stays up and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_word))
		else $error("char word dropped or changed while stalled");

	// a stalled byte word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_word))
		else $error("byte word dropped or changed while stalled");

	// the input only backs up behind a held character
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> char_valid && char_stall)
		else $error("byte_stall without a held character");

	// a cut sequence always closes the string
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_word.truncated |-> char_word.last_character)
		else $error("truncated character without last_character");

	// a cut sequence never has its final six bits filled
	a_trunc_low: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_word.truncated |-> char_word.character[5:0] == 6'd0)
		else $error("truncated character has low bits set");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_word  (byte_word),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_word  (char_word)
);

`default_nettype wire
